/* rtl/rfd_pkg.sv */
// Shared types and constants for the request frame deframer.
// No dependencies; the RTL modules (not the interfaces) import this package.
`default_nettype none

package rfd_pkg;

   // Frame layout
   localparam logic [7:0] MARK_BYTE     = 8'hFF;
   localparam logic [7:0] TYPE_FIRST    = 8'd248;
   localparam logic [7:0] TYPE_LAST     = 8'd251;
   localparam logic [8:0] POS_CLIENT    = 9'd2;
   localparam logic [8:0] POS_MARK3     = 9'd3;
   localparam logic [8:0] POS_TYPE      = 9'd4;
   localparam logic [8:0] POS_SEGMENT   = 9'd5;
   localparam logic [8:0] POS_LENGTH    = 9'd6;
   localparam logic [8:0] PAYLOAD_START = 9'd7;
   localparam logic [8:0] LEN_BIAS      = 9'd8;  // frame overhead minus one
   localparam logic [8:0] COUNT_MAX     = 9'd511;

   // Result kinds
   localparam logic RESULT_PAYLOAD = 1'b0;
   localparam logic RESULT_STATUS  = 1'b1;

   // Status codes beyond the four frame types
   localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd4;
   localparam logic [2:0] STATUS_NO_END       = 3'd5;
   localparam logic [2:0] STATUS_OTHER        = 3'd6;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       final_byte;
   } req_word_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  payload_byte;
      logic [7:0]  payload_index;
      logic [2:0]  frame_status;
      logic [7:0]  client_id;
      logic [7:0]  segment_number;
      logic [7:0]  payload_length;
      logic [7:0]  tech_number;
      logic [39:0] subscriber_number;
   } rsp_word_type;

   // Handshake between the parse stage and its neighbors
   typedef struct packed {
      logic take;  // input word consumed this cycle
      logic push;  // result word written to the output register
   } flow_type;

endpackage

`default_nettype wire

/* rtl/rfd_req_if.sv */
// Request channel: one raw frame byte per word.
// Depends on nothing.
`default_nettype none

interface rfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       final_byte;

   modport source (output valid, output frame_byte, output final_byte, input ready);
   modport sink   (input valid, input frame_byte, input final_byte, output ready);
endinterface

`default_nettype wire

/* rtl/rfd_rsp_if.sv */
// Response channel: payload byte or end-of-frame status word.
// Depends on nothing.
`default_nettype none

interface rfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  payload_byte;
   logic [7:0]  payload_index;
   logic [2:0]  frame_status;
   logic [7:0]  client_id;
   logic [7:0]  segment_number;
   logic [7:0]  payload_length;
   logic [7:0]  tech_number;
   logic [39:0] subscriber_number;

   modport source (output valid, output result_kind, output payload_byte,
                   output payload_index, output frame_status, output client_id,
                   output segment_number, output payload_length, output tech_number,
                   output subscriber_number, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input payload_index, input frame_status, input client_id,
                   input segment_number, input payload_length, input tech_number,
                   input subscriber_number, output ready);
endinterface

`default_nettype wire

/* rtl/request_frame_deframer.sv */
// Request frame deframer. Takes one frame byte per word on req_chan, with final_byte
// marking the frame's last byte, and returns on rsp_chan one word for each payload
// byte (result_kind 0, byte and its index) plus one status word per frame on the
// final byte (result_kind 1) with the frame type or the first error found: bad start
// or type marker or too short, then length mismatch, then missing 0xFF 0xFF end id.
// The status word also carries client id, segment, declared length, tech number and
// the 40-bit subscriber number from payload bytes 0..5 (bytes outside the declared
// length read as zero). Header, end and overflow bytes produce no word. Throughput
// is one byte per clock: a byte goes input register -> parse logic -> output
// register, and its response word is driven onto rsp_chan from the output register.
// The only stall source is a full output register that the sink has not drained.
// Depends on rfd_pkg, rfd_req_if, rfd_rsp_if, rfd_in_stage, rfd_core, rfd_out_stage.
`default_nettype none

module request_frame_deframer
   import rfd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rfd_req_if.sink   req_chan,
   rfd_rsp_if.source rsp_chan
);

   logic         in_valid;
   req_word_type in_word;
   logic         out_free;
   flow_type     flow;
   rsp_word_type result;

   // input word register, refilled in the same cycle it drains
   rfd_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (flow.take),
      .in_valid (in_valid),
      .in_word  (in_word)
   );

   // header checks, captures and status decision
   rfd_core u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_word  (in_word),
      .out_free (out_free),
      .flow     (flow),
      .result   (result)
   );

   // response word register
   rfd_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .push     (flow.push),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* rtl/rfd_in_stage.sv */
// Input register of the deframer: captures one request word.
// Depends on rfd_pkg and rfd_req_if.
`default_nettype none

module rfd_in_stage
   import rfd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   rfd_req_if.sink     req_chan,
   input  wire logic   take,
   output logic        in_valid,
   output req_word_type in_word
);

   logic         valid_ff, valid_in;
   req_word_type word_ff, word_in;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in           = 1'b1;
         word_in.frame_byte = req_chan.frame_byte;
         word_in.final_byte = req_chan.final_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

`default_nettype wire

/* rtl/rfd_core.sv */
// Frame parser: per-frame state and the single-pass step for one byte.
// Depends on rfd_pkg.
`default_nettype none

module rfd_core
   import rfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire req_word_type  in_word,
   input  wire logic          out_free,
   output flow_type           flow,
   output rsp_word_type       result
);

   logic [8:0]  byte_count_ff, byte_count_in;
   logic        header_bad_ff, header_bad_in;
   logic [1:0]  frame_type_ff, frame_type_in;
   logic [7:0]  client_ff, client_in;
   logic [7:0]  segment_ff, segment_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  prev_byte_ff, prev_byte_in;
   logic [7:0]  tech_ff, tech_in;
   logic [39:0] subscriber_ff, subscriber_in;

   logic [7:0]  b;
   logic        fin;
   logic [8:0]  pos;
   logic        bad_now, hdr_bad_now, other;
   logic [8:0]  payload_off;
   logic [7:0]  idx;
   logic        payload_hit, has_result, take;
   logic [2:0]  status;

   assign b   = in_word.frame_byte;
   assign fin = in_word.final_byte;
   assign pos = byte_count_ff;

   always_comb begin
      bad_now = 1'b0;
      if (pos inside {9'd0, 9'd1, POS_MARK3}) begin
         bad_now = (b != MARK_BYTE);
      end else if (pos == POS_TYPE) begin
         bad_now = (b < TYPE_FIRST) || (b > TYPE_LAST);
      end
   end

   assign hdr_bad_now = header_bad_ff | bad_now;
   assign payload_off = pos - PAYLOAD_START;
   assign idx         = payload_off[7:0];
   assign payload_hit = !fin && (pos >= PAYLOAD_START) && (payload_off < {1'b0, length_ff});
   assign has_result  = fin || payload_hit;
   assign take        = in_valid && (!has_result || out_free);
   assign flow.take   = take;
   assign flow.push   = take && has_result;

   // short frame: fewer than 7 bytes means final at position 5 or less
   assign other = hdr_bad_now || (pos < POS_LENGTH);

   always_comb begin
      if (other) begin
         status = STATUS_OTHER;
      end else if ((pos < LEN_BIAS) || ({1'b0, length_ff} != (pos - LEN_BIAS))) begin
         status = STATUS_LEN_MISMATCH;
      end else if ((prev_byte_ff != MARK_BYTE) || (b != MARK_BYTE)) begin
         status = STATUS_NO_END;
      end else begin
         status = {1'b0, frame_type_ff};
      end
   end

   always_comb begin
      result = '0;
      if (fin) begin
         result.result_kind  = RESULT_STATUS;
         result.frame_status = status;
         if (!other) begin
            result.client_id         = client_ff;
            result.segment_number    = segment_ff;
            result.payload_length    = length_ff;
            result.tech_number       = tech_ff;
            result.subscriber_number = subscriber_ff;
         end
      end else begin
         result.result_kind   = RESULT_PAYLOAD;
         result.payload_byte  = b;
         result.payload_index = idx;
      end
   end

   always_comb begin
      byte_count_in = byte_count_ff;
      header_bad_in = header_bad_ff;
      frame_type_in = frame_type_ff;
      client_in     = client_ff;
      segment_in    = segment_ff;
      length_in     = length_ff;
      prev_byte_in  = prev_byte_ff;
      tech_in       = tech_ff;
      subscriber_in = subscriber_ff;
      if (take) begin
         prev_byte_in = b;
         if (fin) begin
            byte_count_in = '0;
            header_bad_in = 1'b0;
            tech_in       = '0;
            subscriber_in = '0;
         end else begin
            header_bad_in = hdr_bad_now;
            if (pos == POS_CLIENT) begin
               client_in = b;
            end
            if ((pos == POS_TYPE) && !bad_now) begin
               frame_type_in = b[1:0];  // type minus 248
            end
            if (pos == POS_SEGMENT) begin
               segment_in = b;
            end
            if (pos == POS_LENGTH) begin
               length_in = b;
            end
            if (byte_count_ff != COUNT_MAX) begin
               byte_count_in = byte_count_ff + 9'd1;
            end
            if (payload_hit) begin
               case (idx)
                  8'd0: tech_in = b;
                  8'd1: subscriber_in[39:32] = subscriber_ff[39:32] | b;
                  8'd2: subscriber_in[31:24] = subscriber_ff[31:24] | b;
                  8'd3: subscriber_in[23:16] = subscriber_ff[23:16] | b;
                  8'd4: subscriber_in[15:8]  = subscriber_ff[15:8]  | b;
                  8'd5: subscriber_in[7:0]   = subscriber_ff[7:0]   | b;
                  default: ;
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         header_bad_ff <= 1'b0;
         frame_type_ff <= '0;
         client_ff     <= '0;
         segment_ff    <= '0;
         length_ff     <= '0;
         prev_byte_ff  <= '0;
         tech_ff       <= '0;
         subscriber_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
         header_bad_ff <= header_bad_in;
         frame_type_ff <= frame_type_in;
         client_ff     <= client_in;
         segment_ff    <= segment_in;
         length_ff     <= length_in;
         prev_byte_ff  <= prev_byte_in;
         tech_ff       <= tech_in;
         subscriber_ff <= subscriber_in;
      end
   end

   // a closed frame restarts at position zero with clean captures
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (take && fin) |=> (byte_count_ff == '0 && !header_bad_ff && subscriber_ff == '0))
      else $error("frame state not cleared after final byte");

   // a result is only written when the output register can hold it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      flow.push |-> (out_free && take))
      else $error("result pushed into a busy output register");

   // counter advances by one per non-final byte until it saturates
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (take && !fin && byte_count_ff != COUNT_MAX) |=>
         (byte_count_ff == $past(byte_count_ff) + 9'd1))
      else $error("byte counter did not advance");

   // payload results only come from the payload window of the frame
   a_payload_window: assert property (@(posedge clock) disable iff (reset)
      (flow.push && !fin) |-> (pos >= PAYLOAD_START))
      else $error("payload word outside the payload window");

endmodule

`default_nettype wire

/* rtl/rfd_out_stage.sv */
// Output register of the deframer: holds one result word until taken.
// Depends on rfd_pkg and rfd_rsp_if.
`default_nettype none

module rfd_out_stage
   import rfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire rsp_word_type  result,
   output logic               out_free,
   rfd_rsp_if.source          rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (push) begin
         valid_in = 1'b1;
         word_in  = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.result_kind       = word_ff.result_kind;
   assign rsp_chan.payload_byte      = word_ff.payload_byte;
   assign rsp_chan.payload_index     = word_ff.payload_index;
   assign rsp_chan.frame_status      = word_ff.frame_status;
   assign rsp_chan.client_id         = word_ff.client_id;
   assign rsp_chan.segment_number    = word_ff.segment_number;
   assign rsp_chan.payload_length    = word_ff.payload_length;
   assign rsp_chan.tech_number       = word_ff.tech_number;
   assign rsp_chan.subscriber_number = word_ff.subscriber_number;

endmodule

`default_nettype wire

/* sim/rfd_frame_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the request frame deframer: mirrors the frame parse on each
// accepted request word and checks every response word in order.
// Depends on rfd_pkg, rfd_req_if and rfd_rsp_if.

module rfd_frame_checker
   import rfd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   rfd_req_if         req_mon,
   rfd_rsp_if         rsp_mon,
   output int         error_count,
   output int         awaited_count,
   output int         payload_checked,
   output int         status_checked,
   output logic [7:0] status_seen
);

   localparam logic [8:0] POS_MARK0      = 9'd0;
   localparam logic [8:0] POS_MARK1      = 9'd1;
   localparam int         FRAME_OVERHEAD = 9;
   localparam int         SUBSCRIBER_END = 5;
   localparam int         MAX_REPORTS    = 10;

   // mirrored parse state
   logic [8:0]  byte_pos;
   logic        header_bad;
   logic [1:0]  frame_type;
   logic [7:0]  client_reg;
   logic [7:0]  segment_reg;
   logic [7:0]  length_reg;
   logic [7:0]  last_byte;
   logic [7:0]  tech_reg;
   logic [39:0] subscriber_reg;

   rsp_word_type awaited_words[$];
   rsp_word_type want;
   rsp_word_type got;
   int           errors = 0;
   int           payload_count = 0;
   int           status_count = 0;
   logic [7:0]   seen = '0;

   function automatic string word_text(input rsp_word_type w);
      return $sformatf("kind %0d byte %02h idx %0d status %0d client %02h seg %02h len %0d tech %02h sub %010h",
                       w.result_kind, w.payload_byte, w.payload_index, w.frame_status,
                       w.client_id, w.segment_number, w.payload_length, w.tech_number,
                       w.subscriber_number);
   endfunction

   task automatic clear_frame();
      byte_pos       = '0;
      header_bad     = 1'b0;
      tech_reg       = '0;
      subscriber_reg = '0;
   endtask

   task automatic parse_frame_byte(input logic [7:0] b, input logic last);
      logic [8:0]   pos;
      int           n;
      int           idx;
      logic         other;
      rsp_word_type w;
      pos = byte_pos;
      w   = '0;
      if (last) begin
         n = int'(pos) + 1;
         if (pos == POS_MARK0 || pos == POS_MARK1 || pos == POS_MARK3) begin
            if (b != MARK_BYTE) header_bad = 1'b1;
         end else if (pos == POS_TYPE) begin
            if (b < TYPE_FIRST || b > TYPE_LAST) header_bad = 1'b1;
         end
         other = header_bad || (n < int'(PAYLOAD_START));
         if (other)
            w.frame_status = STATUS_OTHER;
         else if (n < FRAME_OVERHEAD || int'(length_reg) != n - FRAME_OVERHEAD)
            w.frame_status = STATUS_LEN_MISMATCH;
         else if (last_byte != MARK_BYTE || b != MARK_BYTE)
            w.frame_status = STATUS_NO_END;
         else
            w.frame_status = {1'b0, frame_type};
         w.result_kind = RESULT_STATUS;
         if (!other) begin
            w.client_id         = client_reg;
            w.segment_number    = segment_reg;
            w.payload_length    = length_reg;
            w.tech_number       = tech_reg;
            w.subscriber_number = subscriber_reg;
         end
         awaited_words.push_back(w);
         last_byte = b;
         clear_frame();
      end else begin
         case (pos)
            POS_MARK0, POS_MARK1, POS_MARK3: begin
               if (b != MARK_BYTE) header_bad = 1'b1;
            end
            POS_CLIENT:  client_reg = b;
            POS_TYPE: begin
               if (b < TYPE_FIRST || b > TYPE_LAST) header_bad = 1'b1;
               else frame_type = 2'(b - TYPE_FIRST);
            end
            POS_SEGMENT: segment_reg = b;
            POS_LENGTH:  length_reg = b;
            default: ;
         endcase
         last_byte = b;
         if (byte_pos < COUNT_MAX) byte_pos = byte_pos + 9'd1;
         idx = int'(pos) - int'(PAYLOAD_START);
         if (idx >= 0 && idx < int'(length_reg)) begin
            if (idx == 0)
               tech_reg = b;
            else if (idx <= SUBSCRIBER_END)
               subscriber_reg = subscriber_reg | (40'(b) << (8 * (SUBSCRIBER_END - idx)));
            w.result_kind   = RESULT_PAYLOAD;
            w.payload_byte  = b;
            w.payload_index = 8'(idx);
            awaited_words.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         frame_type  = '0;
         client_reg  = '0;
         segment_reg = '0;
         length_reg  = '0;
         last_byte   = '0;
         awaited_words.delete();
      end else begin
         // compare first: a word leaving now never belongs to a byte taken now
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got.result_kind       = rsp_mon.result_kind;
            got.payload_byte      = rsp_mon.payload_byte;
            got.payload_index     = rsp_mon.payload_index;
            got.frame_status      = rsp_mon.frame_status;
            got.client_id         = rsp_mon.client_id;
            got.segment_number    = rsp_mon.segment_number;
            got.payload_length    = rsp_mon.payload_length;
            got.tech_number       = rsp_mon.tech_number;
            got.subscriber_number = rsp_mon.subscriber_number;
            if (awaited_words.size() == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("%0t: unexpected response word: %s", $time, word_text(got));
            end else begin
               want = awaited_words.pop_front();
               if (got.result_kind !== want.result_kind
                   || got.payload_byte !== want.payload_byte
                   || got.payload_index !== want.payload_index
                   || got.frame_status !== want.frame_status
                   || got.client_id !== want.client_id
                   || got.segment_number !== want.segment_number
                   || got.payload_length !== want.payload_length
                   || got.tech_number !== want.tech_number
                   || got.subscriber_number !== want.subscriber_number) begin
                  errors++;
                  if (errors <= MAX_REPORTS) begin
                     $display("%0t: response mismatch, expected %s", $time, word_text(want));
                     $display("%0t:                      actual %s", $time, word_text(got));
                  end
               end
            end
            if (got.result_kind === RESULT_STATUS) begin
               status_count++;
               if (!$isunknown(got.frame_status)) seen[got.frame_status] = 1'b1;
            end else begin
               payload_count++;
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            parse_frame_byte(req_mon.frame_byte, req_mon.final_byte);
      end
      error_count     <= errors;
      awaited_count   <= awaited_words.size();
      payload_checked <= payload_count;
      status_checked  <= status_count;
      status_seen     <= seen;
   end

endmodule

/* sim/tb_request_frame_deframer.sv */
`timescale 1ns / 1ps
// Top of the request frame deframer testbench: clock, reset, frame stimulus and
// response back-pressure, with the scoreboard checker beside the block.
// Depends on rfd_pkg, rfd_req_if, rfd_rsp_if, request_frame_deframer, rfd_frame_checker.

module tb_request_frame_deframer;
   import rfd_pkg::*;

   localparam int RANDOM_BYTES       = 160;
   localparam int DRAIN_CYCLES       = 8;
   localparam int SATURATING_PAYLOAD = 515;  // drives the byte counter into saturation at 511
   localparam int MAX_DECLARED       = 255;
   localparam int SHORT_LEN_MAX      = 8;    // covers payloads shorter than 6 bytes
   localparam int LONG_LEN_MAX       = 40;

   logic       clock = 1'b0;
   logic       reset;
   logic       no_idle;      // sink starts no new stall while set
   int         ready_left = 0;
   int         bytes_sent = 0;
   int         frames_sent = 0;
   int         random_start;
   logic [7:0] frame_bytes[$];

   int         error_count;
   int         awaited_count;
   int         payload_checked;
   int         status_checked;
   logic [7:0] status_seen;

   rfd_req_if req_chan ();
   rfd_rsp_if rsp_chan ();

   request_frame_deframer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   rfd_frame_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .error_count     (error_count),
      .awaited_count   (awaited_count),
      .payload_checked (payload_checked),
      .status_checked  (status_checked),
      .status_seen     (status_seen)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle span: mostly none, else from a narrow random range or, now and then, a wide one up to long_max.
   function automatic int pick_gap(input int long_max);
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, long_max);
   endfunction

   // Declared payload length: mostly short, so missing subscriber bytes show up.
   function automatic int pick_len();
      if ($urandom_range(0, 99) < 80) return $urandom_range(0, SHORT_LEN_MAX);
      return $urandom_range(SHORT_LEN_MAX + 1, LONG_LEN_MAX);
   endfunction

   // Response back-pressure: alternating ready runs and stalls of random length.
   // ready_left counts the cycles left in the current phase.
   always @(posedge clock) begin
      if (ready_left > 0) begin
         ready_left <= ready_left - 1;
      end else if (no_idle || rsp_chan.ready !== 1'b1) begin
         rsp_chan.ready <= 1'b1;
         ready_left     <= $urandom_range(0, 20);
      end else begin
         rsp_chan.ready <= 1'b0;
         ready_left     <= pick_gap(60);
      end
   end

   // One request word; valid stays high across back-to-back words and only
   // drops when a gap is inserted in front of the next one.
   task automatic send_byte(input logic [7:0] value, input logic last, input logic quiet);
      int gap;
      gap = quiet ? 0 : pick_gap(40);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.frame_byte <= value;
      req_chan.final_byte <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      bytes_sent++;
   endtask

   // Sends frame_bytes with the final flag on its last byte. About one frame in
   // eight runs with no request gaps and no new response stalls.
   task automatic send_frame();
      logic quiet;
      quiet = ($urandom_range(0, 7) == 0);
      no_idle <= quiet;
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, quiet);
      frames_sent++;
   endtask

   // Well-formed frame layout with random header fields and payload content;
   // declared and actual payload sizes are given separately.
   task automatic build_frame(input logic [7:0] declared, input int payload_count);
      int k;
      frame_bytes.delete();
      frame_bytes.push_back(MARK_BYTE);
      frame_bytes.push_back(MARK_BYTE);
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(MARK_BYTE);
      frame_bytes.push_back(8'($urandom_range(TYPE_FIRST, TYPE_LAST)));
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(declared);
      for (k = 0; k < payload_count; k++) frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(MARK_BYTE);
      frame_bytes.push_back(MARK_BYTE);
   endtask

   // Random frame: mostly well-formed, the rest broken in one of several ways
   // so that every status code and every early final position gets exercised.
   task automatic send_random_frame();
      int         r;
      int         declared;
      int         actual;
      int         keep;
      int         k;
      int         tail;
      logic [7:0] v;
      r        = $urandom_range(0, 99);
      declared = pick_len();
      tail     = 0;
      if (r < 58) begin
         build_frame(8'(declared), declared);
      end else if (r < 70) begin
         // declared length disagrees with the bytes actually sent
         do actual = pick_len(); while (actual == declared);
         build_frame(8'(declared), actual);
      end else if (r < 78) begin
         // end id damaged: last, second to last, or both
         build_frame(8'(declared), declared);
         tail = frame_bytes.size() - 1;
         case ($urandom_range(0, 2))
            0: frame_bytes[tail] = 8'($urandom_range(0, 254));
            1: frame_bytes[tail - 1] = 8'($urandom_range(0, 254));
            default: begin
               frame_bytes[tail]     = 8'($urandom_range(0, 254));
               frame_bytes[tail - 1] = 8'($urandom_range(0, 254));
            end
         endcase
      end else if (r < 86) begin
         // header damaged; half the time the length is wrong too, to check
         // that the header error wins
         build_frame(8'(declared), $urandom_range(0, 1) ? declared : pick_len());
         case ($urandom_range(0, 3))
            0: frame_bytes[0] = 8'($urandom_range(0, 254));
            1: frame_bytes[1] = 8'($urandom_range(0, 254));
            2: frame_bytes[POS_MARK3] = 8'($urandom_range(0, 254));
            default: begin
               do v = 8'($urandom); while (v >= TYPE_FIRST && v <= TYPE_LAST);
               frame_bytes[POS_TYPE] = v;
            end
         endcase
      end else if (r < 94) begin
         // cut short: the final flag lands anywhere inside the frame
         build_frame(8'(declared), declared);
         keep = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
      end else begin
         // line noise, sometimes with a plausible start
         frame_bytes.delete();
         keep = $urandom_range(1, 16);
         for (k = 0; k < keep; k++) frame_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 1)) begin
            frame_bytes[0] = MARK_BYTE;
            if (keep > 1) frame_bytes[1] = MARK_BYTE;
         end
      end
      send_frame();
   endtask

   initial begin
      reset               <= 1'b1;
      no_idle             <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.frame_byte <= '0;
      req_chan.final_byte <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed frames.
      // One-byte frame with a zero start byte: too short, other error.
      frame_bytes = '{8'h00};
      send_frame();
      // Smallest good frame: empty payload, lowest type, client 0, segment 255.
      frame_bytes = '{MARK_BYTE, MARK_BYTE, 8'h00, MARK_BYTE, TYPE_FIRST, 8'hFF, 8'h00,
                      MARK_BYTE, MARK_BYTE};
      send_frame();
      // Highest type with a single all-ones payload byte; subscriber bytes
      // beyond the declared length read as zero.
      frame_bytes = '{MARK_BYTE, MARK_BYTE, 8'hFF, MARK_BYTE, TYPE_LAST, 8'h00, 8'h01,
                      8'hFF, MARK_BYTE, MARK_BYTE};
      send_frame();
      // Type byte just below the valid range, closing the frame on that byte.
      frame_bytes = '{MARK_BYTE, MARK_BYTE, 8'h5A, MARK_BYTE, 8'hF7};
      send_frame();

      // Random frames.
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) send_random_frame();

      // Longest declared payload inside an over-length frame: indices up to
      // 254, then the byte counter saturates, so length mismatch.
      build_frame(8'(MAX_DECLARED), SATURATING_PAYLOAD);
      send_frame();

      req_chan.valid <= 1'b0;
      // let the checker book the last word before we look
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d request words in %0d frames: directed, random, full-length over-length",
               bytes_sent, frames_sent);
      $display("checked %0d payload and %0d status words, status codes seen %b",
               payload_checked, status_checked, status_seen);
      if (error_count == 0 && awaited_count == 0) begin
         $display("request_frame_deframer verification clean");
      end else begin
         $display("request_frame_deframer verification failed");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("request_frame_deframer verification failed");
      $finish;
   end

endmodule
